[design/camera_pixel_to_rgba_converter_unit_macros.svh]
// Assertion macros shared by the checker of the pixel converter.
`ifndef CAMERA_PIXEL_TO_RGBA_CONVERTER_UNIT_MACROS_SVH
`define CAMERA_PIXEL_TO_RGBA_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pixel converter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pixel converter check failed");

`endif

[design/cpr_pkg.sv]
// Shared types, codes and constants of the camera pixel converter.
`timescale 1ns / 1ps

package cpr_pkg;

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
	} in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_item;
	} out_t;

	// Pixel format register codes.
	localparam logic [2:0] FMT_RGBA = 3'd0;
	localparam logic [2:0] FMT_BGRA = 3'd1;
	localparam logic [2:0] FMT_RGB  = 3'd2;
	localparam logic [2:0] FMT_YUYV = 3'd3;
	localparam logic [2:0] FMT_NV12 = 3'd4;

	// Command kinds passed from the front to the back.
	localparam logic [1:0] KIND_DIRECT = 2'd0;
	localparam logic [1:0] KIND_YUV    = 2'd1;
	localparam logic [1:0] KIND_PAIR   = 2'd2;

	// Direct: p0..p3 = R G B A. Yuv: p0 = Y, p1 = U, p2 = V.
	// Pair: p0 = Y0, p1 = U, p2 = V, p3 = Y1.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
	} cmd_t;

	localparam int QUEUE_DEPTH = 4;

	localparam int PROD_W = 20;
	localparam int SUM_W  = 22;

	localparam logic signed [PROD_W-1:0] Y_OFS = 20'sd16;
	localparam logic signed [PROD_W-1:0] C_OFS = 20'sd128;

	// BT.601 video-range coefficients, Q10.
	localparam logic signed [PROD_W-1:0] K_Y  = 20'sd1192;
	localparam logic signed [PROD_W-1:0] K_RV = 20'sd1634;
	localparam logic signed [PROD_W-1:0] K_GU = 20'sd400;
	localparam logic signed [PROD_W-1:0] K_GV = 20'sd833;
	localparam logic signed [PROD_W-1:0] K_BU = 20'sd2066;

	// Drop negatives, shift out the fraction, saturate at 255.
	function automatic logic [7:0] clamp_q10(input logic signed [SUM_W-1:0] s);
		logic [7:0] r;
		if (s[SUM_W-1]) begin
			r = 8'd0;
		end else if (|s[SUM_W-2:18]) begin
			r = 8'hFF;
		end else begin
			r = s[17:10];
		end
		return r;
	endfunction

endpackage

[design/cpr_front.sv]
// Front end: format register, input accept and classification into commands.
`timescale 1ns / 1ps

module cpr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [2:0]       cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  cpr_pkg::in_t     in_data,
	input  logic             push_ready,
	output logic             push_valid,
	output cpr_pkg::cmd_t    push_cmd
);

	logic [2:0] fmt_q;
	logic       known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= cpr_pkg::FMT_RGBA;
		end else if (cfg_wen) begin
			fmt_q <= cfg_wdata;
		end
	end

	always_comb begin
		known         = 1'b1;
		push_cmd.kind = cpr_pkg::KIND_DIRECT;
		push_cmd.p0   = in_data.byte0;
		push_cmd.p1   = in_data.byte1;
		push_cmd.p2   = in_data.byte2;
		push_cmd.p3   = in_data.byte3;
		case (fmt_q)
			cpr_pkg::FMT_RGBA: begin
			end
			cpr_pkg::FMT_BGRA: begin
				push_cmd.p0 = in_data.byte2;
				push_cmd.p2 = in_data.byte0;
			end
			cpr_pkg::FMT_RGB: begin
				push_cmd.p3 = 8'hFF;
			end
			cpr_pkg::FMT_YUYV: begin
				push_cmd.kind = cpr_pkg::KIND_PAIR;
				push_cmd.p2   = in_data.byte3;
				push_cmd.p3   = in_data.byte2;
			end
			cpr_pkg::FMT_NV12: begin
				push_cmd.kind = cpr_pkg::KIND_YUV;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// Items of an unused format are taken and dropped.
	assign in_ready   = push_ready;
	assign push_valid = in_valid && known;

endmodule

[design/cpr_fifo.sv]
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module cpr_fifo #(
	parameter int DEPTH = cpr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cpr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          head_valid,
	output cpr_pkg::cmd_t head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cpr_pkg::cmd_t mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/cpr_back.sv]
// Back end: pixel issue, YCbCr products, sum and clamp, output register.
`timescale 1ns / 1ps

module cpr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  cpr_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output cpr_pkg::out_t out_data
);

	localparam int PW = cpr_pkg::PROD_W;
	localparam int SW = cpr_pkg::SUM_W;

	logic                 phase_q;
	logic                 en;
	logic                 issue;
	logic                 second;
	logic [7:0]           y_sel;
	logic signed [PW-1:0] yy;
	logic signed [PW-1:0] cb;
	logic signed [PW-1:0] cr;

	logic                 valid_s1;
	logic                 yuv_s1;
	logic                 last_s1;
	logic [31:0]          rgba_s1;
	logic signed [PW-1:0] base_s1;
	logic signed [PW-1:0] rv_s1;
	logic signed [PW-1:0] gu_s1;
	logic signed [PW-1:0] gv_s1;
	logic signed [PW-1:0] bu_s1;

	logic signed [SW-1:0] sum_r;
	logic signed [SW-1:0] sum_g;
	logic signed [SW-1:0] sum_b;

	logic                 valid_s2;
	cpr_pkg::out_t        data_s2;

	// Whole back advances together when the output slot is free or taken.
	assign en     = !valid_s2 || out_ready;
	assign issue  = en && head_valid;
	assign second = (head_cmd.kind == cpr_pkg::KIND_PAIR) && phase_q;
	assign pop    = issue && ((head_cmd.kind != cpr_pkg::KIND_PAIR) || phase_q);

	assign y_sel = second ? head_cmd.p3 : head_cmd.p0;
	assign yy    = $signed({{(PW-8){1'b0}}, y_sel}) - cpr_pkg::Y_OFS;
	assign cb    = $signed({{(PW-8){1'b0}}, head_cmd.p1}) - cpr_pkg::C_OFS;
	assign cr    = $signed({{(PW-8){1'b0}}, head_cmd.p2}) - cpr_pkg::C_OFS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			if (head_valid && head_cmd.kind == cpr_pkg::KIND_PAIR) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			yuv_s1  <= (head_cmd.kind != cpr_pkg::KIND_DIRECT);
			last_s1 <= (head_cmd.kind != cpr_pkg::KIND_PAIR) || phase_q;
			rgba_s1 <= {head_cmd.p0, head_cmd.p1, head_cmd.p2, head_cmd.p3};
			base_s1 <= yy * cpr_pkg::K_Y;
			rv_s1   <= cr * cpr_pkg::K_RV;
			gu_s1   <= cb * cpr_pkg::K_GU;
			gv_s1   <= cr * cpr_pkg::K_GV;
			bu_s1   <= cb * cpr_pkg::K_BU;
		end
	end

	assign sum_r = SW'(base_s1) + SW'(rv_s1);
	assign sum_g = SW'(base_s1) - SW'(gu_s1) - SW'(gv_s1);
	assign sum_b = SW'(base_s1) + SW'(bu_s1);

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2.last_of_item <= last_s1;
			if (yuv_s1) begin
				data_s2.red   <= cpr_pkg::clamp_q10(sum_r);
				data_s2.green <= cpr_pkg::clamp_q10(sum_g);
				data_s2.blue  <= cpr_pkg::clamp_q10(sum_b);
				data_s2.alpha <= 8'hFF;
			end else begin
				data_s2.red   <= rgba_s1[31:24];
				data_s2.green <= rgba_s1[23:16];
				data_s2.blue  <= rgba_s1[15:8];
				data_s2.alpha <= rgba_s1[7:0];
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

[design/camera_pixel_to_rgba_converter_unit.sv]
// Top level of the camera pixel to RGBA8 converter.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | request   | in_valid / in_ready    | in_data (byte0..byte3)
//  out     | result    | out_valid / out_ready  | out_data (rgba, last_of_item)
//  cfg     | write     | cfg_wen                | cfg_wdata (pixel format)
//
//  The back issues one pixel per cycle while the output is not stalled: a YUYV
//  request yields two pixels, every other format one, through the single issue port of the back.
//  A queued request passes from the queue through the s1 registers into the output register.
//  Reset clears the queue, the pipeline valids and the format (RGBA).
//  A stalled output freezes the back only; the front keeps queuing requests
//  until the queue (QUEUE_DEPTH entries) fills.

module camera_pixel_to_rgba_converter_unit #(
	parameter int QUEUE_DEPTH = cpr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [2:0]    cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  cpr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cpr_pkg::out_t out_data
);

	logic          push_valid;
	logic          push_ready;
	cpr_pkg::cmd_t push_cmd;
	logic          pop;
	logic          head_valid;
	cpr_pkg::cmd_t head_cmd;

	// Classify each request by format and map its bytes.
	cpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_cmd   (push_cmd)
	);

	// Hold commands so front and back stall independently.
	cpr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Expand commands into pixels and drive the output register.
	cpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

[design/cpr_checker.sv]
// Port-level checker of the pixel converter and its bind.
`timescale 1ns / 1ps
`include "camera_pixel_to_rgba_converter_unit_macros.svh"

module cpr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input cpr_pkg::out_t out_data
);

	// A stalled result stays offered.
	`CPR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// A stalled result keeps its payload.
	`CPR_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))

	// Only YUYV yields a first-of-two pixel, and that one is opaque.
	`CPR_ASSERT_IMP(a_first_opaque, clk, arst_n, out_valid && !out_data.last_of_item, out_data.alpha == 8'hFF)

	// The second pixel of a pair follows right after the first is taken.
	`CPR_ASSERT_NXT(a_pair_follows, clk, arst_n, out_valid && out_ready && !out_data.last_of_item, out_valid && out_data.last_of_item)

endmodule

bind camera_pixel_to_rgba_converter_unit cpr_checker u_cpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
